// File: sv/dltq_pkg.sv
// Package for the delta-list timeout queue: opcodes, status codes and widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dltq_pkg;
    localparam int DefEntries  = 16;
    localparam int DefTickBits = 32;
    localparam int MaxResults  = 16;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_ZERO        = 2'd1;
    localparam logic [1:0] ST_WAITING     = 2'd2;
    localparam logic [1:0] ST_NOT_WAITING = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  entry_id;
        logic [31:0] timeout_ticks;
        logic [2:0]  object_type;
    } in_word_t;

    typedef struct packed {
        logic       is_expiry;
        logic [3:0] expired_entry;
        logic [2:0] expired_type;
        logic [1:0] status;
        logic       last;
    } out_word_t;
endpackage
`default_nettype wire

// File: sv/dltq_if.sv
// Valid/ready channel interface carrying one word of a given type.
// Depends on dltq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dltq_if
    import dltq_pkg::*;
#(
    parameter type word_t = in_word_t
);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/delta_list_timeout_queue_unit.sv
// Delta-list timeout queue: the list lives in one RAM word per entry.
// Depends on dltq_pkg, dltq_if and dltq_ram.
//
//  channel  | dir | word        | meaning
//  in_ch    | in  | in_word_t   | tick, insert or cancel
//  out_ch   | out | out_word_t  | acknowledgement or expiry report
//
// One item at a time. Every list access is a read of the entry RAM, whose read
// data is registered, followed by a write. Reset empties the list by clearing
// the waiting flags and the head; the RAM is not cleared. A stalled output
// holds the sequencer in place.
`timescale 1ns / 1ps
`default_nettype none
module delta_list_timeout_queue_unit
    import dltq_pkg::*;
#(
    parameter int ENTRIES   = DefEntries,
    parameter int TICK_BITS = DefTickBits
) (
    input wire logic clk,
    input wire logic rst_n,
    dltq_if.sink     in_ch,
    dltq_if.source   out_ch
);
    localparam int IW = $clog2(ENTRIES);
    localparam int LW = IW + 1;
    localparam int RW = TICK_BITS + 2 * LW + 3;
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);

    typedef struct packed {
        logic [TICK_BITS-1:0] delta;
        logic [LW-1:0]        nxt;
        logic [LW-1:0]        prv;
        logic [2:0]           typ;
    } rec_t;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WALKR = 4'd1;
    localparam logic [3:0] S_WALK  = 4'd2;
    localparam logic [3:0] S_INSN  = 4'd3;
    localparam logic [3:0] S_INSP  = 4'd4;
    localparam logic [3:0] S_ULR   = 4'd5;
    localparam logic [3:0] S_UL    = 4'd6;
    localparam logic [3:0] S_ULN   = 4'd8;
    localparam logic [3:0] S_ULP   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_TICKR = 4'd12;
    localparam logic [3:0] S_TICK  = 4'd13;

    logic [3:0]           state_reg, state_next;
    logic [ENTRIES-1:0]   wait_reg, wait_next;
    logic [LW-1:0]        head_reg, head_next;
    logic [IW-1:0]        id_reg, id_next;
    logic [2:0]           typ_reg, typ_next;
    logic [TICK_BITS-1:0] d_reg, d_next;
    logic [LW-1:0]        cur_reg, cur_next;
    logic [LW-1:0]        pv_reg, pv_next;
    logic                 is_tick_reg, is_tick_next;
    logic                 first_reg, first_next;
    logic                 more_reg, more_next;
    logic [4:0]           cnt_reg, cnt_next;
    rec_t                 rec_reg, rec_next;
    out_word_t            ow_reg, ow_next;
    logic                 ov_reg, ov_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    rec_t          wdata, rdata;

    dltq_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    in_word_t iw;
    assign iw = in_ch.data;
    assign in_ch.ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data = ow_reg;

    logic id_ok;
    logic [TICK_BITS-1:0] tin;
    logic [TICK_BITS-1:0] sum_delta;
    assign id_ok = ({28'd0, iw.entry_id} < 32'(ENTRIES));
    assign tin = TICK_BITS'(64'(iw.timeout_ticks));
    assign sum_delta = rdata.delta + rec_reg.delta;

    always_comb
    begin
        state_next = state_reg;
        wait_next = wait_reg;
        head_next = head_reg;
        id_next = id_reg;
        typ_next = typ_reg;
        d_next = d_reg;
        cur_next = cur_reg;
        pv_next = pv_reg;
        is_tick_next = is_tick_reg;
        first_next = first_reg;
        more_next = more_reg;
        cnt_next = cnt_reg;
        rec_next = rec_reg;
        ow_next = ow_reg;
        ov_next = ov_reg;
        we = 1'b0;
        waddr = id_reg;
        wdata = rdata;
        raddr = cur_reg[IW-1:0];
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && !ov_reg)
                begin
                    id_next = iw.entry_id[IW-1:0];
                    typ_next = iw.object_type;
                    is_tick_next = (iw.opcode == OP_TICK);
                    more_next = 1'b0;
                    ow_next = '{1'b0, iw.entry_id, iw.object_type, ST_OK, 1'b1};
                    if (iw.opcode == OP_TICK)
                    begin
                        if (head_reg != NIL)
                        begin
                            cur_next = head_reg;
                            first_next = 1'b1;
                            is_tick_next = 1'b1;
                            cnt_next = '0;
                            state_next = S_TICKR;
                        end
                    end
                    else if (iw.opcode == OP_INSERT)
                    begin
                        if (!id_ok)
                        begin
                            ow_next.status = ST_NOT_WAITING;
                            ov_next = 1'b1;
                        end
                        else if (tin == '0)
                        begin
                            ow_next.status = ST_ZERO;
                            ov_next = 1'b1;
                        end
                        else if (wait_reg[iw.entry_id[IW-1:0]])
                        begin
                            ow_next.status = ST_WAITING;
                            ov_next = 1'b1;
                        end
                        else
                        begin
                            d_next = tin;
                            cur_next = head_reg;
                            pv_next = NIL;
                            cnt_next = '0;
                            state_next = S_WALKR;
                        end
                    end
                    else if (iw.opcode == OP_CANCEL)
                    begin
                        if (!id_ok || !wait_reg[iw.entry_id[IW-1:0]])
                        begin
                            ow_next.expired_type = 3'd0;
                            ow_next.status = ST_NOT_WAITING;
                            ov_next = 1'b1;
                        end
                        else
                        begin
                            cur_next = {1'b0, iw.entry_id[IW-1:0]};
                            is_tick_next = 1'b0;
                            state_next = S_ULR;
                        end
                    end
                end
            end
            S_WALKR:
            begin
                // Walk ends at the list end or after ENTRIES steps.
                if (cur_reg == NIL || 32'(cnt_reg) >= 32'(ENTRIES))
                begin
                    cur_next = NIL;
                    state_next = S_INSN;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (rdata.delta <= d_reg)
                begin
                    d_next = d_reg - rdata.delta;
                    pv_next = cur_reg;
                    cur_next = rdata.nxt;
                    cnt_next = cnt_reg + 5'd1;
                    state_next = S_WALKR;
                end
                else
                begin
                    // Successor: give up the part of its delta now held here.
                    we = 1'b1;
                    waddr = cur_reg[IW-1:0];
                    wdata = rdata;
                    wdata.delta = rdata.delta - d_reg;
                    wdata.prv = {1'b0, id_reg};
                    state_next = S_INSN;
                end
            end
            S_INSN:
            begin
                we = 1'b1;
                waddr = id_reg;
                wdata = '{d_reg, cur_reg, pv_reg, typ_reg};
                wait_next[id_reg] = 1'b1;
                raddr = pv_reg[IW-1:0];
                if (pv_reg == NIL)
                begin
                    head_next = {1'b0, id_reg};
                    ov_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_INSP;
                end
            end
            S_INSP:
            begin
                we = 1'b1;
                waddr = pv_reg[IW-1:0];
                wdata = rdata;
                wdata.nxt = {1'b0, id_reg};
                ov_next = 1'b1;
                state_next = S_OUT;
            end
            S_TICKR:
            begin
                raddr = cur_reg[IW-1:0];
                state_next = S_TICK;
            end
            S_TICK:
            begin
                if (first_reg && rdata.delta != '0)
                begin
                    first_next = 1'b0;
                    we = 1'b1;
                    waddr = cur_reg[IW-1:0];
                    wdata = rdata;
                    wdata.delta = rdata.delta - 1'b1;
                    if (rdata.delta == TICK_BITS'(1))
                    begin
                        state_next = S_TICKR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (rdata.delta == '0 && cnt_reg < 5'(MaxResults))
                begin
                    first_next = 1'b0;
                    id_next = cur_reg[IW-1:0];
                    is_tick_next = 1'b1;
                    raddr = cur_reg[IW-1:0];
                    state_next = S_UL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ULR:
            begin
                raddr = cur_reg[IW-1:0];
                state_next = S_UL;
            end
            S_UL:
            begin
                rec_next = rdata;
                wait_next[id_reg] = 1'b0;
                raddr = rdata.nxt[IW-1:0];
                if (rdata.prv == NIL)
                begin
                    head_next = rdata.nxt;
                end
                state_next = S_ULN;
            end
            S_ULN:
            begin
                raddr = rec_reg.prv[IW-1:0];
                if (rec_reg.nxt != NIL)
                begin
                    we = 1'b1;
                    waddr = rec_reg.nxt[IW-1:0];
                    wdata = rdata;
                    wdata.delta = sum_delta;
                    wdata.prv = rec_reg.prv;
                end
                // A tick goes on only if the new head also expires now.
                more_next = is_tick_reg && (rec_reg.nxt != NIL) && (sum_delta == '0)
                    && (cnt_reg < 5'(MaxResults - 1));
                state_next = S_ULP;
            end
            S_ULP:
            begin
                if (rec_reg.prv != NIL)
                begin
                    we = 1'b1;
                    waddr = rec_reg.prv[IW-1:0];
                    wdata = rdata;
                    wdata.nxt = rec_reg.nxt;
                end
                ow_next = '{is_tick_reg, 4'(id_reg), rec_reg.typ, ST_OK, 1'b1};
                if (is_tick_reg)
                begin
                    cnt_next = cnt_reg + 5'd1;
                    cur_next = rec_reg.nxt;
                    ow_next.last = !more_reg;
                end
                ov_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Wait for the word to leave; a tick then goes on with the new head.
                if (ov_reg && out_ch.ready)
                begin
                    if (more_reg)
                    begin
                        state_next = S_TICKR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg <= '0;
            head_reg <= NIL;
            ov_reg <= 1'b0;
            more_reg <= 1'b0;
            cnt_reg <= '0;
            first_reg <= 1'b0;
            is_tick_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg <= wait_next;
            head_reg <= head_next;
            ov_reg <= ov_next;
            more_reg <= more_next;
            cnt_reg <= cnt_next;
            first_reg <= first_next;
            is_tick_reg <= is_tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        typ_reg <= typ_next;
        d_reg <= d_next;
        cur_reg <= cur_next;
        pv_reg <= pv_next;
        rec_reg <= rec_next;
        ow_reg <= ow_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |-> state_reg == S_IDLE)
        else $error("word accepted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg == NIL |-> wait_reg == '0)
        else $error("empty list with waiting entries");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'(MaxResults))
        else $error("expiry count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output word changed while stalled");
endmodule
`default_nettype wire

// File: sv/dltq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: tb/sv/delta_list_timeout_queue_unit_tb.sv
// Testbench for the delta-list timeout queue: a directed table, then random
// tick/insert/cancel and unused-opcode words, each checked against a behavioral list model.
// Depends on dltq_pkg, dltq_if and delta_list_timeout_queue_unit.
`timescale 1ns / 1ps
`default_nettype none
module delta_list_timeout_queue_unit_tb;
    import dltq_pkg::*;

    localparam int NUM_ENTRIES = 16;
    localparam int NIL = NUM_ENTRIES;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    dltq_if #(.word_t(in_word_t))  in_ch();
    dltq_if #(.word_t(out_word_t)) out_ch();

    delta_list_timeout_queue_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Model of the delta list.
    logic [31:0] ticks_left [NUM_ENTRIES];
    int          succ [NUM_ENTRIES];
    int          pred [NUM_ENTRIES];
    logic        armed [NUM_ENTRIES];
    logic [2:0]  tag [NUM_ENTRIES];
    int          first;

    out_word_t pending_results[$];
    int        errors;
    int        cycles;
    bit        quiet;

    task automatic report(input string what, input out_word_t got, input out_word_t want);
        $display("mismatch %s: got %p want %p", what, got, want);
        errors++;
    endtask

    function automatic void detach(input int e);
        int nx;
        int pv;
        nx = succ[e];
        pv = pred[e];
        if (nx != NIL)
        begin
            ticks_left[nx] = ticks_left[nx] + ticks_left[e];
            pred[nx] = pv;
        end
        if (pv != NIL)
            succ[pv] = nx;
        else
            first = nx;
        succ[e] = NIL;
        pred[e] = NIL;
        armed[e] = 1'b0;
    endfunction

    function automatic void push_result(input logic x, input logic [3:0] e,
                                        input logic [2:0] t, input logic [1:0] s,
                                        input logic l);
        out_word_t r;
        r.is_expiry = x;
        r.expired_entry = e;
        r.expired_type = t;
        r.status = s;
        r.last = l;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_queue(input in_word_t w);
        int n;
        int cur;
        int pv;
        logic [31:0] d;
        n = 0;
        case (w.opcode)
            OP_TICK:
            begin
                if (first != NIL)
                begin
                    if (ticks_left[first] > 0)
                        ticks_left[first]--;
                    while (n < MaxResults && first != NIL && ticks_left[first] == 0)
                    begin
                        cur = first;
                        detach(cur);
                        push_result(1'b1, cur[3:0], tag[cur], ST_OK, 1'b0);
                        n++;
                    end
                    if (n > 0)
                        pending_results[$].last = 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (w.timeout_ticks == 0)
                    push_result(1'b0, w.entry_id, w.object_type, ST_ZERO, 1'b1);
                else if (armed[w.entry_id])
                    push_result(1'b0, w.entry_id, w.object_type, ST_WAITING, 1'b1);
                else
                begin
                    d = w.timeout_ticks;
                    cur = first;
                    pv = NIL;
                    while (cur != NIL && ticks_left[cur] <= d)
                    begin
                        d -= ticks_left[cur];
                        pv = cur;
                        cur = succ[cur];
                    end
                    ticks_left[w.entry_id] = d;
                    tag[w.entry_id] = w.object_type;
                    succ[w.entry_id] = cur;
                    pred[w.entry_id] = pv;
                    if (cur != NIL)
                    begin
                        ticks_left[cur] -= d;
                        pred[cur] = w.entry_id;
                    end
                    if (pv != NIL)
                        succ[pv] = w.entry_id;
                    else
                        first = w.entry_id;
                    armed[w.entry_id] = 1'b1;
                    push_result(1'b0, w.entry_id, w.object_type, ST_OK, 1'b1);
                end
            end
            OP_CANCEL:
            begin
                if (!armed[w.entry_id])
                    push_result(1'b0, w.entry_id, 3'd0, ST_NOT_WAITING, 1'b1);
                else
                begin
                    detach(w.entry_id);
                    push_result(1'b0, w.entry_id, tag[w.entry_id], ST_OK, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // Directed rows; a row with has_want set also carries its typed-in result.
    typedef struct {
        in_word_t  w;
        bit        has_want;
        out_word_t want;
    } table_row_t;

    function automatic in_word_t mk(input logic [1:0] op, input logic [3:0] e,
                                    input logic [31:0] t, input logic [2:0] ty);
        in_word_t w;
        w.opcode = op;
        w.entry_id = e;
        w.timeout_ticks = t;
        w.object_type = ty;
        return w;
    endfunction

    function automatic out_word_t ack(input logic [3:0] e, input logic [2:0] t,
                                      input logic [1:0] s);
        out_word_t r;
        r.is_expiry = 1'b0;
        r.expired_entry = e;
        r.expired_type = t;
        r.status = s;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.data <= w;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_queue(w);
        @(negedge clk);
    endtask

    // Sink side: random stall bursts, checks each accepted result.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 18);
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected word", out_ch.data, out_ch.data);
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.data.is_expiry !== want.is_expiry)
                    report("is_expiry", out_ch.data, want);
                else if (out_ch.data.expired_entry !== want.expired_entry)
                    report("expired_entry", out_ch.data, want);
                else if (out_ch.data.expired_type !== want.expired_type)
                    report("expired_type", out_ch.data, want);
                else if (out_ch.data.status !== want.status)
                    report("status", out_ch.data, want);
                else if (out_ch.data.last !== want.last)
                    report("last", out_ch.data, want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("FAIL");
            $finish;
        end
    end

    function automatic in_word_t random_word();
        int pick;
        logic [31:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            t = $urandom_range(1, 6);
        else if (pick < 40)
            t = $urandom;
        else if (pick < 45)
            t = 32'd0;
        else
            t = $urandom_range(1, 30);
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return mk(OP_TICK, 4'($urandom), $urandom, 3'($urandom));
        else if (pick < 80)
            return mk(OP_INSERT, 4'($urandom), t, 3'($urandom));
        else if (pick < 97)
            return mk(OP_CANCEL, 4'($urandom), $urandom, 3'($urandom));
        return mk(2'd3, 4'($urandom), $urandom, 3'($urandom));
    endfunction

    initial
    begin
        table_row_t rows[$];
        table_row_t row;
        int wait_cycles;
        errors = 0;
        cycles = 0;
        quiet = 0;
        first = NIL;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            ticks_left[i] = 0;
            succ[i] = NIL;
            pred[i] = NIL;
            armed[i] = 1'b0;
            tag[i] = 3'd0;
        end
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        row.has_want = 0;
        row.want = '0;
        // Tick on an empty list, unused opcode, errors on idle entries, an insert and its repeat.
        row.w = mk(OP_TICK, 4'd0, 32'd0, 3'd0); rows.push_back(row);
        row.w = mk(2'd3, 4'd15, 32'hFFFF_FFFF, 3'd7); rows.push_back(row);
        row.has_want = 1;
        row.w = mk(OP_CANCEL, 4'd15, 32'd0, 3'd7);
        row.want = ack(4'd15, 3'd0, ST_NOT_WAITING); rows.push_back(row);
        row.w = mk(OP_INSERT, 4'd0, 32'd0, 3'd5);
        row.want = ack(4'd0, 3'd5, ST_ZERO); rows.push_back(row);
        row.w = mk(OP_INSERT, 4'd15, 32'hFFFF_FFFF, 3'd7);
        row.want = ack(4'd15, 3'd7, ST_OK); rows.push_back(row);
        row.w = mk(OP_INSERT, 4'd15, 32'd3, 3'd1);
        row.want = ack(4'd15, 3'd1, ST_WAITING); rows.push_back(row);
        row.has_want = 0;
        // Equal timeouts queue in arrival order and one is cancelled; a tick with no expiry.
        row.w = mk(OP_INSERT, 4'd1, 32'd2, 3'd1); rows.push_back(row);
        row.w = mk(OP_INSERT, 4'd2, 32'd2, 3'd2); rows.push_back(row);
        row.w = mk(OP_INSERT, 4'd3, 32'd1, 3'd3); rows.push_back(row);
        row.w = mk(OP_INSERT, 4'd4, 32'd5, 3'd4); rows.push_back(row);
        row.w = mk(OP_CANCEL, 4'd2, 32'd0, 3'd0); rows.push_back(row);
        row.w = mk(OP_TICK, 4'd0, 32'd0, 3'd0); rows.push_back(row);
        row.w = mk(OP_TICK, 4'd0, 32'd0, 3'd0); rows.push_back(row);
        row.w = mk(OP_TICK, 4'd0, 32'd0, 3'd0); rows.push_back(row);
        row.w = mk(OP_CANCEL, 4'd15, 32'd0, 3'd0); rows.push_back(row);
        row.w = mk(OP_CANCEL, 4'd4, 32'd0, 3'd0); rows.push_back(row);
        // All sixteen entries at once: one tick reports them all.
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            row.w = mk(OP_INSERT, 4'(i), 32'd1, 3'(i));
            rows.push_back(row);
        end
        row.w = mk(OP_TICK, 4'd0, 32'd0, 3'd0); rows.push_back(row);
        foreach (rows[i])
        begin
            if (rows[i].has_want)
            begin
                send_word(rows[i].w);
                if (pending_results[$] != rows[i].want)
                    report("table row", pending_results[$], rows[i].want);
            end
            else
                send_word(rows[i].w);
        end

        for (int i = 0; i < 200; i++)
        begin
            if (i >= 160)
                quiet = 1;
            send_word(random_word());
        end
        // Send up to 40 ticks to drain what is still waiting.
        for (int i = 0; i < 40 && first != NIL; i++)
            send_word(mk(OP_TICK, 4'($urandom), $urandom, 3'($urandom)));
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
